// ===== hdl/block_buffer_cache_lru_unit_assert.svh =====
// Assertion macros for the block buffer cache LRU unit.
// Depends on a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef BLOCK_BUFFER_CACHE_LRU_UNIT_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBCL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bbcl_pkg.sv =====
// Package for the block buffer cache LRU unit: sizes, operation and status codes, states.
// No dependencies.
package bbcl_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_W  = 5;
	localparam int DEV_W   = 8;
	localparam int BLK_W   = 32;
	localparam int TAG_W   = DEV_W + BLK_W;
	localparam int STAMP_W = 32;
	localparam int REFS_W  = 8;
	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	localparam int IN_BITS   = DEV_W + BLK_W + SLOT_W + STAMP_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = SLOT_W + 1 + 1 + 2;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		KIND_GET     = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_PIN     = 2'd2,
		KIND_UNPIN   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_COMMIT,
		S_PUT
	} state_t;

endpackage

// ===== hdl/block_buffer_cache_lru_unit.sv =====
// Block buffer cache LRU unit: fully associative tag search and free-entry LRU replacement.
// A get reads the memories once per entry through a single tag and stamp compare unit, then
// drains the read (S_LAST), commits (S_COMMIT) and loads its result beat (S_PUT). Release,
// pin and unpin go straight to the commit and the output load. Input is ready again the cycle
// after the load, so a new request is taken only once the last one is through, and later while
// a waiting result holds the output register. Reset is asynchronous, active low.
module block_buffer_cache_lru_unit
	import bbcl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// device[7:0], block_number[39:8], slot[44:40], now[76:45], zero fill above.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind[1:0].
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// slot_out[4:0], hit[5], needs_fill[6], status[8:7], zero fill above.
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// Reset is low and clears control state, reference counts, valid bits and stamp-written bits.

	`include "block_buffer_cache_lru_unit_assert.svh"

	state_t state_q, state_d;

	kind_t              kind_q;
	logic [DEV_W-1:0]   dev_q;
	logic [BLK_W-1:0]   blk_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [STAMP_W-1:0] now_q;

	logic [IDX_W-1:0] addr_q;
	logic             accept;
	logic             scan_last;

	logic [TAG_W-1:0]   tag_mem [ENTRIES];
	logic [STAMP_W-1:0] stamp_mem [ENTRIES];
	logic [REFS_W-1:0]  refs_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] stok_q;

	logic               rd_v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [STAMP_W-1:0] stamp_s1;
	logic [REFS_W-1:0]  refs_s1;
	logic               valid_s1;
	logic               stok_s1;
	logic [STAMP_W-1:0] eff_stamp;

	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               vic_found_q;
	logic [IDX_W-1:0]   vic_idx_q;
	logic [STAMP_W-1:0] vic_stamp_q;

	logic [IDX_W-1:0]  refs_addr;
	logic [REFS_W-1:0] refs_rd;
	logic [IDX_W-1:0]  tgt_idx;
	logic              refs_we;
	logic [REFS_W-1:0] refs_wd;
	logic              tag_we;
	logic              stamp_we;
	logic              valid_set;

	logic [SLOT_W+IDX_W-1:0] slot_ext;
	logic [IDX_W-1:0]        slot_idx;
	logic                    slot_in_range;
	logic [SLOT_W+IDX_W-1:0] hit_ext;
	logic [SLOT_W+IDX_W-1:0] vic_ext;

	logic [SLOT_W-1:0] res_slot;
	logic              res_hit;
	logic              res_fill;
	status_t           res_status;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_hit_q;
	logic              res_fill_q;
	status_t           res_status_q;

	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_data_q;
	logic                  out_load;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign scan_last = (32'(addr_q) == 32'(ENTRIES - 1));

	assign slot_ext      = {{IDX_W{1'b0}}, slot_q};
	assign slot_idx      = slot_ext[IDX_W-1:0];
	assign slot_in_range = (32'(slot_q) < 32'(ENTRIES));
	assign hit_ext       = {{SLOT_W{1'b0}}, hit_idx_q};
	assign vic_ext       = {{SLOT_W{1'b0}}, vic_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (kind_t'(s_axis_tuser) == KIND_GET) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_COMMIT;
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_PUT;
			end
			S_PUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(s_axis_tuser);
			dev_q  <= s_axis_tdata[DEV_W-1:0];
			blk_q  <= s_axis_tdata[DEV_W+BLK_W-1:DEV_W];
			slot_q <= s_axis_tdata[DEV_W+BLK_W+SLOT_W-1:DEV_W+BLK_W];
			now_q  <= s_axis_tdata[IN_BITS-1:DEV_W+BLK_W+SLOT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_SCAN);
			if (accept) begin
				addr_q <= '0;
			end else if (state_q == S_SCAN) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// Tag and stamp memories: one write port, one registered read port at the scan address.
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tgt_idx] <= {blk_q, dev_q};
		end
		if (stamp_we) begin
			stamp_mem[tgt_idx] <= now_q;
		end
		if (state_q == S_SCAN) begin
			tag_s1   <= tag_mem[addr_q];
			stamp_s1 <= stamp_mem[addr_q];
			refs_s1  <= refs_rd;
			valid_s1 <= valid_q[addr_q];
			stok_s1  <= stok_q[addr_q];
			idx_s1   <= addr_q;
		end
	end

	assign refs_addr = (state_q == S_SCAN) ? addr_q : tgt_idx;
	assign refs_rd   = refs_q[refs_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				refs_q[i] <= '0;
			end
			valid_q <= '0;
			stok_q  <= '0;
		end else begin
			if (refs_we) begin
				refs_q[tgt_idx] <= refs_wd;
			end
			if (valid_set) begin
				valid_q[tgt_idx] <= 1'b1;
			end
			if (stamp_we) begin
				stok_q[tgt_idx] <= 1'b1;
			end
		end
	end

	// A stamp that was never written reads as zero.
	assign eff_stamp = stok_s1 ? stamp_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q <= 1'b0;
			vic_found_q <= 1'b0;
		end else if (accept) begin
			hit_found_q <= 1'b0;
			vic_found_q <= 1'b0;
		end else if (rd_v_s1) begin
			if (!hit_found_q && valid_s1 && (tag_s1 == {blk_q, dev_q})) begin
				hit_found_q <= 1'b1;
			end
			if ((refs_s1 == '0) && (!vic_found_q || (eff_stamp < vic_stamp_q))) begin
				vic_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			if (!hit_found_q && valid_s1 && (tag_s1 == {blk_q, dev_q})) begin
				hit_idx_q <= idx_s1;
			end
			if ((refs_s1 == '0) && (!vic_found_q || (eff_stamp < vic_stamp_q))) begin
				vic_idx_q   <= idx_s1;
				vic_stamp_q <= eff_stamp;
			end
		end
	end

	always_comb begin
		tgt_idx    = slot_idx;
		refs_we    = 1'b0;
		refs_wd    = refs_rd;
		tag_we     = 1'b0;
		stamp_we   = 1'b0;
		valid_set  = 1'b0;
		res_slot   = slot_q;
		res_hit    = 1'b0;
		res_fill   = 1'b0;
		res_status = ST_OK;
		if (kind_q == KIND_GET) begin
			if (hit_found_q) begin
				tgt_idx  = hit_idx_q;
				res_slot = hit_ext[SLOT_W-1:0];
				res_hit  = 1'b1;
				if (refs_rd == REFS_MAX) begin
					res_status = ST_OVERFLOW;
				end else begin
					refs_we = 1'b1;
					refs_wd = refs_rd + 1'b1;
				end
			end else if (vic_found_q) begin
				tgt_idx   = vic_idx_q;
				res_slot  = vic_ext[SLOT_W-1:0];
				res_fill  = 1'b1;
				refs_we   = 1'b1;
				refs_wd   = REFS_W'(1);
				tag_we    = 1'b1;
				stamp_we  = 1'b1;
				valid_set = 1'b1;
			end else begin
				res_slot   = '0;
				res_status = ST_NO_FREE;
			end
		end else if (slot_in_range) begin
			if (kind_q == KIND_PIN) begin
				if (refs_rd == REFS_MAX) begin
					res_status = ST_OVERFLOW;
				end else begin
					refs_we = 1'b1;
					refs_wd = refs_rd + 1'b1;
				end
			end else if (refs_rd == '0) begin
				res_status = ST_UNDERFLOW;
			end else begin
				refs_we = 1'b1;
				refs_wd = refs_rd - 1'b1;
				if ((kind_q == KIND_RELEASE) && (refs_rd == REFS_W'(1))) begin
					stamp_we = 1'b1;
				end
			end
		end
		if (state_q != S_COMMIT) begin
			refs_we   = 1'b0;
			tag_we    = 1'b0;
			stamp_we  = 1'b0;
			valid_set = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_COMMIT) begin
			res_slot_q   <= res_slot;
			res_hit_q    <= res_hit;
			res_fill_q   <= res_fill;
			res_status_q <= res_status;
		end
		if (out_load) begin
			out_data_q <= {res_status_q, res_fill_q, res_hit_q, res_slot_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_data_q};

	`BBCL_ASSERT_SAME(a_hit_no_fill, m_axis_tvalid && m_axis_tdata[SLOT_W], !m_axis_tdata[SLOT_W+1], "hit beat also asks for a fill")
	`BBCL_ASSERT_SAME(a_fill_ok, m_axis_tvalid && m_axis_tdata[SLOT_W+1], m_axis_tdata[OUT_BITS-1:SLOT_W+2] == ST_OK, "fill beat carries an error status")
	`BBCL_ASSERT_NEXT(a_victim_valid, (state_q == S_COMMIT) && (kind_q == KIND_GET) && !hit_found_q && vic_found_q, valid_q[vic_idx_q] && (refs_q[vic_idx_q] == REFS_W'(1)), "replaced entry not valid with one reference")

endmodule
